// ----- rtl/skf_pkg.sv -----
// Shared constants, widths and handshake status type for the scalar Kalman filter.
// No dependencies; imported by every module of the block.
package skf_pkg;

    // Filter configuration
    localparam int AXES      = 3;
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int AXIS_W     = 2;
    localparam int DATA_W     = 32;
    localparam int REG_W      = 24;
    localparam int CFG_ADDR_W = 2;

    // Stream bus widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    // Gain is 0..2^FRAC_BITS, so one bit above the fraction
    localparam int K_W   = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    // Serial datapath widths
    localparam int PSUM_W = DATA_W + 1;     // P' + R, exact
    localparam int INNV_W = DATA_W + 1;     // z - x, exact
    localparam int ACCE_W = DATA_W + 3;     // estimate correction accumulator
    localparam int ACCV_W = DATA_W + 2;     // variance product accumulator

    // Configuration register indices
    localparam logic [CFG_ADDR_W-1:0] REG_MEAS_NOISE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_PROC_NOISE = CFG_ADDR_W'(1);

    localparam logic [REG_W-1:0] MEAS_NOISE_RST = REG_W'(197);
    localparam logic [REG_W-1:0] PROC_NOISE_RST = REG_W'(983);

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } skf_unit_sts_t;

endpackage

// ----- rtl/skf_div.sv -----
// Restoring bit-serial divider for the Kalman gain K = floor(P' * 2^FRAC_BITS / S).
// One quotient bit per cycle; depends on skf_pkg.
module skf_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [skf_pkg::DATA_W-1:0]    num,
    input  logic [skf_pkg::PSUM_W-1:0]    den,
    output logic [skf_pkg::K_W-1:0]       quot,
    output skf_pkg::skf_unit_sts_t        sts
);
    import skf_pkg::*;

    logic [PSUM_W-1:0] rem_reg,  rem_next;
    logic [PSUM_W-1:0] den_reg,  den_next;
    logic [K_W-1:0]    quot_reg, quot_next;
    logic              zero_reg, zero_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [PSUM_W:0]   shl;
    logic              ge;

    // trial subtract of the doubled remainder
    assign shl = {rem_reg, 1'b0};
    assign ge  = shl >= {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // num <= den, so the integer bit is set only when they are equal
            den_next  = den;
            zero_next = (den == '0);
            cnt_next  = '0;
            busy_next = 1'b1;
            if ({1'b0, num} >= den) begin
                rem_next  = {1'b0, num} - den;
                quot_next = K_W'(1);
            end else begin
                rem_next  = {1'b0, num};
                quot_next = '0;
            end
        end else if (busy_reg) begin
            rem_next  = ge ? PSUM_W'(shl - {1'b0, den_reg}) : PSUM_W'(shl);
            quot_next = {quot_reg[K_W-2:0], ge};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(FRAC_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        zero_reg <= zero_next;
    end

    // zero divisor gives zero gain
    assign quot     = zero_reg ? '0 : quot_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ----- rtl/skf_mac.sv -----
// Serial shift-add multipliers for the update: floor(K*innov / 2^F) and
// floor(P' * (2^F - K) / 2^F), one multiplier bit per cycle. Depends on skf_pkg.
module skf_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [skf_pkg::K_W-1:0]              gain,
    input  logic signed [skf_pkg::INNV_W-1:0]    innov,
    input  logic [skf_pkg::DATA_W-1:0]           p_pred,
    output logic signed [skf_pkg::ACCE_W-1:0]    delta,
    output logic [skf_pkg::ACCV_W-1:0]           p_scaled,
    output skf_pkg::skf_unit_sts_t               sts
);
    import skf_pkg::*;

    localparam logic [K_W-1:0] K_ONE = K_W'(1) << FRAC_BITS;

    logic [K_W-1:0]           k_sh_reg,  k_sh_next;
    logic [K_W-1:0]           j_sh_reg,  j_sh_next;
    logic signed [INNV_W-1:0] innov_reg, innov_next;
    logic [DATA_W-1:0]        p_reg,     p_next;
    logic signed [ACCE_W-1:0] acc_e_reg, acc_e_next;
    logic [ACCV_W-1:0]        acc_v_reg, acc_v_next;
    logic [CNT_W-1:0]         cnt_reg,   cnt_next;
    logic                     busy_reg,  busy_next;
    logic                     done_reg,  done_next;

    logic signed [ACCE_W-1:0] e_sum;
    logic [ACCV_W-1:0]        v_sum;
    logic                     last;

    // LSB first: bits shifted out below the binary point are dropped, which
    // is exactly a floor of the full product
    assign e_sum = acc_e_reg + (k_sh_reg[0] ? ACCE_W'(innov_reg) : '0);
    assign v_sum = acc_v_reg + (j_sh_reg[0] ? {2'b00, p_reg} : '0);
    assign last  = (cnt_reg == CNT_W'(FRAC_BITS));

    always_comb begin
        k_sh_next  = k_sh_reg;
        j_sh_next  = j_sh_reg;
        innov_next = innov_reg;
        p_next     = p_reg;
        acc_e_next = acc_e_reg;
        acc_v_next = acc_v_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            k_sh_next  = gain;
            j_sh_next  = K_ONE - gain;
            innov_next = innov;
            p_next     = p_pred;
            acc_e_next = '0;
            acc_v_next = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            k_sh_next = k_sh_reg >> 1;
            j_sh_next = j_sh_reg >> 1;
            cnt_next  = cnt_reg + CNT_W'(1);
            if (last) begin
                // integer bit of the multiplier: no shift
                acc_e_next = e_sum;
                acc_v_next = v_sum;
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end else begin
                acc_e_next = e_sum >>> 1;
                acc_v_next = v_sum >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        k_sh_reg  <= k_sh_next;
        j_sh_reg  <= j_sh_next;
        innov_reg <= innov_next;
        p_reg     <= p_next;
        acc_e_reg <= acc_e_next;
        acc_v_reg <= acc_v_next;
    end

    assign delta    = acc_e_reg;
    assign p_scaled = acc_v_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// ----- rtl/scalar_kalman_filter.sv -----
// Scalar Kalman filter top level: channel handshakes, per-axis stores, sequencer.
// Depends on skf_pkg, skf_div and skf_mac.
// Each accepted request runs the sequencer (load, gain divide, multiply, output) at Q16.16;
// no new request is accepted until it has been handed to the output register, as the serial gain
// divider (one quotient bit a cycle) and then the serial shift-add multiplier work on one request.
// Reset (aresetn, synchronous, active low): stores zero, R and Q to defaults, output empty.
module scalar_kalman_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [skf_pkg::S_TDATA_W-1:0]     s_tdata,   // [1:0] axis, [33:2] measurement
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [skf_pkg::M_TDATA_W-1:0]     m_tdata,   // [1:0] axis_out, [33:2] estimate,
                                                         // [65:34] variance
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [skf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [skf_pkg::REG_W-1:0]         cfg_wdata
);
    import skf_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a request
    localparam logic [2:0] ST_LOAD  = 3'd1;  // read stores, predict P' = P + Q
    localparam logic [2:0] ST_DIV   = 3'd2;  // kick the gain divider
    localparam logic [2:0] ST_DWAIT = 3'd3;  // wait for K, then kick the multiplier
    localparam logic [2:0] ST_MWAIT = 3'd4;  // wait for products, form x', P'
    localparam logic [2:0] ST_OUT   = 3'd5;  // write back and hand to output register

    localparam int PAD_W = M_TDATA_W - AXIS_W - 2 * DATA_W;

    logic [2:0]               state_reg, state_next;

    // configuration
    logic [REG_W-1:0]         meas_noise_reg;
    logic [REG_W-1:0]         proc_noise_reg;

    // per-axis state
    logic signed [DATA_W-1:0] est_store_reg [AXES];
    logic [DATA_W-1:0]        var_store_reg [AXES];

    // request in flight
    logic [AXIS_W-1:0]        axis_reg;
    logic signed [DATA_W-1:0] z_reg;
    logic                     axis_ok_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0]        p_reg;
    logic [K_W-1:0]           k_reg;
    logic signed [DATA_W-1:0] xn_reg;
    logic [DATA_W-1:0]        pn_reg;

    // output register
    logic                     m_valid_reg;
    logic [M_TDATA_W-1:0]     m_data_reg;

    // datapath
    logic                     axis_ok;
    logic [DATA_W:0]          p_sum;
    logic [DATA_W-1:0]        p_sat;
    logic [PSUM_W-1:0]        s_sum;
    logic signed [INNV_W-1:0] innov;
    logic signed [ACCE_W-1:0] delta;
    logic [ACCV_W-1:0]        p_scaled;
    logic signed [ACCE_W:0]   x_sum;
    logic signed [DATA_W-1:0] x_sat;
    logic [DATA_W-1:0]        pn_sat;
    logic [K_W-1:0]           k_div;
    logic                     out_free;

    skf_unit_sts_t            div_sts;
    skf_unit_sts_t            mac_sts;

    assign axis_ok = ({1'b0, s_tdata[AXIS_W-1:0]} < (AXIS_W + 1)'(AXES));

    // predict: P' = P + Q, saturating
    assign p_sum = {1'b0, var_store_reg[axis_reg]} + (DATA_W + 1)'(proc_noise_reg);
    assign p_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

    // innovation covariance S = P' + R, exact at 33 bits
    assign s_sum = {1'b0, p_reg} + PSUM_W'(meas_noise_reg);

    // innovation z - x, exact
    assign innov = INNV_W'(z_reg) - INNV_W'(x_reg);

    // x + floor(K*innov/2^F), saturated to the signed 32-bit range
    assign x_sum = (ACCE_W + 1)'(x_reg) + (ACCE_W + 1)'(delta);
    always_comb begin
        if (x_sum[ACCE_W:DATA_W-1] == '0 || x_sum[ACCE_W:DATA_W-1] == '1) begin
            x_sat = x_sum[DATA_W-1:0];
        end else if (x_sum[ACCE_W]) begin
            x_sat = {1'b1, {(DATA_W - 1){1'b0}}};
        end else begin
            x_sat = {1'b0, {(DATA_W - 1){1'b1}}};
        end
    end

    assign pn_sat = (p_scaled[ACCV_W-1:DATA_W] != '0) ? '1 : p_scaled[DATA_W-1:0];

    skf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_DIV),
        .num     (p_reg),
        .den     (s_sum),
        .quot    (k_div),
        .sts     (div_sts)
    );

    skf_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    ((state_reg == ST_DWAIT) && div_sts.done),
        .gain     (k_div),
        .innov    (innov),
        .p_pred   (p_reg),
        .delta    (delta),
        .p_scaled (p_scaled),
        .sts      (mac_sts)
    );

    // output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // out-of-range axis skips the arithmetic, result fields zero
                state_next = axis_ok_reg ? ST_DIV : ST_OUT;
            end
            ST_DIV: begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_sts.done) begin
                    state_next = ST_MWAIT;
                end
            end
            ST_MWAIT: begin
                if (mac_sts.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, configuration and stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            meas_noise_reg <= MEAS_NOISE_RST;
            proc_noise_reg <= PROC_NOISE_RST;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                est_store_reg[i] <= '0;
                var_store_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_MEAS_NOISE: meas_noise_reg <= cfg_wdata;
                    REG_PROC_NOISE: proc_noise_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                if (axis_ok_reg) begin
                    est_store_reg[axis_reg] <= xn_reg;
                    var_store_reg[axis_reg] <= pn_reg;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            axis_reg    <= s_tdata[AXIS_W-1:0];
            z_reg       <= s_tdata[AXIS_W +: DATA_W];
            axis_ok_reg <= axis_ok;
            xn_reg      <= '0;
            pn_reg      <= '0;
        end
        if (state_reg == ST_LOAD && axis_ok_reg) begin
            x_reg <= est_store_reg[axis_reg];
            p_reg <= p_sat;
        end
        if (state_reg == ST_DWAIT && div_sts.done) begin
            k_reg <= k_div;
        end
        if (state_reg == ST_MWAIT && mac_sts.done) begin
            // K of zero means the estimate holds; the serial product gives that
            xn_reg <= (k_reg == '0) ? x_reg : x_sat;
            pn_reg <= pn_sat;
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg <= {{PAD_W{1'b0}}, pn_reg, xn_reg, axis_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
